### hw/rtl/csv_pkg.sv
// shared types and constants for the csv line and field splitter
`timescale 1ns / 1ps
`default_nettype none

package csv_pkg;

   // default field limit per record
   localparam int MaxFieldsDefault = 256;

   // special characters
   localparam logic [7:0] CharQuote = 8'h22;
   localparam logic [7:0] CharComma = 8'h2C;
   localparam logic [7:0] CharCr    = 8'h0D;
   localparam logic [7:0] CharLf    = 8'h0A;
   localparam logic [7:0] CharNul   = 8'h00;

   // parse mode within one field
   typedef enum logic [2:0] {
      MODE_START,
      MODE_UNQUOTED,
      MODE_QUOTED,
      MODE_QUOTE_SEEN,
      MODE_TAIL
   } mode_type;

   // input word
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_input;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic [7:0] field_index;
      logic       end_of_field;
      logic       end_of_record;
      logic [8:0] field_count;
   } rsp_word_type;

endpackage

`default_nettype wire

### hw/rtl/csv_line_field_splitter.sv
// csv line and field splitter top level
//
// Usage: one text byte (or an end-of-input mark) enters per req word; each
// word causes zero or one rsp word: a field byte, an end of field, or an end
// of record with the field count. Lines end with CR, LF or CR LF; quoted
// fields keep commas and fold doubled quotes.
// The rsp word is registered and appears in the cycle after its req word is accepted.
// Throughput: one req word per cycle while req_stall is low; the parse
// state is a handful of registers updated by a single byte decode, so the
// decode never limits the rate below one byte per clock.
// The result register sits between the channels: req_stall rises only when
// a result is waiting and the receiver holds rsp_stall high, so words that
// arrive while no result waits, or as a result drains, are taken at once.
// Reset (synchronous, active high) returns to the start of a fresh line
// and drops any pending result.
// Field index and count saturate at MAX_FIELDS-1 and MAX_FIELDS.
`timescale 1ns / 1ps
`default_nettype none

module csv_line_field_splitter #(
   parameter int MAX_FIELDS = csv_pkg::MaxFieldsDefault
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  csv_pkg::req_word_type  req_word,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output csv_pkg::rsp_word_type  rsp_word
);

   localparam int FieldWidth = $clog2(MAX_FIELDS);
   localparam int ExtWidth   = (FieldWidth + 1 > 9) ? FieldWidth + 1 : 9;
   localparam logic [FieldWidth-1:0] FieldLast = FieldWidth'(MAX_FIELDS - 1);

   // parse state
   csv_pkg::mode_type      mode_ff, mode_in;
   logic                   after_cr_ff, after_cr_in;
   logic                   line_started_ff, line_started_in;
   logic                   has_content_ff, has_content_in;
   logic                   dropping_ff, dropping_in;
   logic [FieldWidth-1:0]  field_ff, field_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   csv_pkg::rsp_word_type  rsp_word_ff, rsp_word_in;

   // decode of the accepted word
   logic                   accept;
   logic [7:0]             ch;
   logic                   eoi;
   logic                   lf_skip;
   logic                   is_newline;
   logic                   body;
   logic                   is_nul;
   logic                   proc;
   logic                   close_line;
   logic                   do_emit;
   logic                   do_end_field;
   logic [ExtWidth-1:0]    field_ext;
   logic [ExtWidth-1:0]    count_ext;

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // byte classification
   always_comb begin
      ch         = req_word.data_byte;
      eoi        = req_word.end_of_input;
      lf_skip    = !eoi && after_cr_ff && (ch == csv_pkg::CharLf);
      is_newline = !eoi && !lf_skip && ((ch == csv_pkg::CharCr) || (ch == csv_pkg::CharLf));
      body       = !eoi && !lf_skip && !is_newline;
      is_nul     = body && !dropping_ff && (ch == csv_pkg::CharNul);
      proc       = body && !dropping_ff && (ch != csv_pkg::CharNul);
      close_line = (eoi && line_started_ff) || is_newline;
   end

   // field action for a parsed byte
   always_comb begin
      do_emit      = 1'b0;
      do_end_field = 1'b0;
      mode_in      = mode_ff;
      case (mode_ff)
         csv_pkg::MODE_START: begin
            if (ch == csv_pkg::CharQuote) begin
               mode_in = csv_pkg::MODE_QUOTED;
            end else if (ch == csv_pkg::CharComma) begin
               do_end_field = 1'b1;
            end else begin
               mode_in = csv_pkg::MODE_UNQUOTED;
               do_emit = 1'b1;
            end
         end
         csv_pkg::MODE_QUOTED: begin
            if (ch == csv_pkg::CharQuote) begin
               mode_in = csv_pkg::MODE_QUOTE_SEEN;
            end else begin
               do_emit = 1'b1;
            end
         end
         csv_pkg::MODE_QUOTE_SEEN: begin
            if (ch == csv_pkg::CharQuote) begin
               mode_in = csv_pkg::MODE_QUOTED;
               do_emit = 1'b1;
            end else if (ch == csv_pkg::CharComma) begin
               do_end_field = 1'b1;
            end else begin
               mode_in = csv_pkg::MODE_TAIL;
               do_emit = 1'b1;
            end
         end
         default: begin
            if (ch == csv_pkg::CharComma) begin
               do_end_field = 1'b1;
            end else begin
               do_emit = 1'b1;
            end
         end
      endcase
      if (do_end_field) begin
         mode_in = csv_pkg::MODE_START;
      end
   end

   // next parse state
   always_comb begin
      after_cr_in     = after_cr_ff;
      line_started_in = line_started_ff;
      has_content_in  = has_content_ff;
      dropping_in     = dropping_ff;
      field_in        = field_ff;
      if (accept) begin
         after_cr_in = is_newline && (ch == csv_pkg::CharCr);
         if (eoi || is_newline) begin
            line_started_in = 1'b0;
            has_content_in  = 1'b0;
            dropping_in     = 1'b0;
            field_in        = '0;
         end else if (body) begin
            line_started_in = 1'b1;
            if (is_nul) begin
               dropping_in = 1'b1;
            end
            if (proc) begin
               has_content_in = 1'b1;
               if (do_end_field && (field_ff != FieldLast)) begin
                  field_in = field_ff + 1'b1;
               end
            end
         end
      end
   end

   // result word
   always_comb begin
      field_ext   = ExtWidth'(field_ff);
      count_ext   = field_ext + ExtWidth'(1);
      rsp_word_in = '0;
      if (close_line) begin
         rsp_word_in.end_of_record = 1'b1;
         if (has_content_ff) begin
            rsp_word_in.end_of_field = 1'b1;
            rsp_word_in.field_index  = field_ext[7:0];
            rsp_word_in.field_count  = count_ext[8:0];
         end
      end else if (proc && do_emit) begin
         rsp_word_in.out_byte    = ch;
         rsp_word_in.has_byte    = 1'b1;
         rsp_word_in.field_index = field_ext[7:0];
      end else if (proc && do_end_field) begin
         rsp_word_in.end_of_field = 1'b1;
         rsp_word_in.field_index  = field_ext[7:0];
      end
   end

   // result register load and drain
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept && (close_line || (proc && (do_emit || do_end_field)))) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= csv_pkg::MODE_START;
         after_cr_ff     <= 1'b0;
         line_started_ff <= 1'b0;
         has_content_ff  <= 1'b0;
         dropping_ff     <= 1'b0;
         field_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            if (eoi || is_newline) begin
               mode_ff <= csv_pkg::MODE_START;
            end else if (proc) begin
               mode_ff <= mode_in;
            end
         end
         after_cr_ff     <= after_cr_in;
         line_started_ff <= line_started_in;
         has_content_ff  <= has_content_in;
         dropping_ff     <= dropping_in;
         field_ff        <= field_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (!(rsp_valid_ff && rsp_stall)) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // a line end leaves a fresh line behind
   assert property (@(posedge clock) disable iff (reset)
      accept && is_newline |=> (mode_ff == csv_pkg::MODE_START) && (field_ff == '0)
         && !line_started_ff && !dropping_ff)
      else $error("line end did not reset line state");

   // a field byte never carries an end mark
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.has_byte |-> !rsp_word_ff.end_of_field
         && !rsp_word_ff.end_of_record)
      else $error("field byte with end mark");

   // dropping after nul only inside a started line
   assert property (@(posedge clock) disable iff (reset)
      dropping_ff |-> line_started_ff)
      else $error("nul drop outside a line");

   // input held off only by a waiting result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall)
      else $error("input stalled without a pending result");

endmodule

`default_nettype wire

### dv/tb_csv_line_field_splitter.sv
// self-checking testbench for the csv line and field splitter
`timescale 1ns / 1ps

module tb_csv_line_field_splitter;

   localparam int          FieldLimit    = csv_pkg::MaxFieldsDefault;
   localparam int          HoldOffCycles = 300;
   localparam int          QuietLimit    = 4000;
   localparam int          PhaseWords    = 450;
   localparam logic [8:0]  LastIndex     = 9'(FieldLimit - 1);

   // parse model and store of expected words
   class csv_parse_tracker;
      csv_pkg::mode_type     mode;
      bit                    after_cr;
      bit                    line_started;
      bit                    line_has_content;
      bit                    dropping;
      logic [8:0]            field_idx;
      csv_pkg::rsp_word_type parsed_words[$];
      int                    words_noted;
      int                    words_checked;
      int                    records_closed;
      int                    errors;

      function new();
         clear_line();
         after_cr = 1'b0;
      endfunction

      function void clear_line();
         mode             = csv_pkg::MODE_START;
         line_started     = 1'b0;
         line_has_content = 1'b0;
         dropping         = 1'b0;
         field_idx        = '0;
      endfunction

      function csv_pkg::rsp_word_type make_word(logic [7:0] b, logic has, logic eof,
                                                logic eor, logic [8:0] count);
         csv_pkg::rsp_word_type w;
         w.out_byte      = b;
         w.has_byte      = has;
         w.field_index   = field_idx[7:0];
         w.end_of_field  = eof;
         w.end_of_record = eor;
         w.field_count   = count;
         return w;
      endfunction

      // field end: report current index, then move on (saturating)
      function csv_pkg::rsp_word_type end_field();
         csv_pkg::rsp_word_type w;
         w = make_word(8'h00, 1'b0, 1'b1, 1'b0, 9'd0);
         if (field_idx < LastIndex) field_idx++;
         mode = csv_pkg::MODE_START;
         return w;
      endfunction

      // line end: a line whose first byte was a terminator or nul has no fields
      function csv_pkg::rsp_word_type close_line();
         csv_pkg::rsp_word_type w;
         if (line_has_content) begin
            w = make_word(8'h00, 1'b0, 1'b1, 1'b1, field_idx + 9'd1);
         end else begin
            field_idx = '0;
            w = make_word(8'h00, 1'b0, 1'b0, 1'b1, 9'd0);
         end
         clear_line();
         return w;
      endfunction

      // one input word in, zero or one expected word out
      function bit parse_byte(csv_pkg::req_word_type in_word,
                              output csv_pkg::rsp_word_type w);
         logic [7:0] c;
         c = in_word.data_byte;
         w = '0;
         if (in_word.end_of_input) begin
            after_cr = 1'b0;
            if (line_started) begin
               w = close_line();
               return 1'b1;
            end
            clear_line();
            return 1'b0;
         end
         if (after_cr) begin
            after_cr = 1'b0;
            if (c == csv_pkg::CharLf) return 1'b0;
         end
         if (c == csv_pkg::CharCr || c == csv_pkg::CharLf) begin
            after_cr = (c == csv_pkg::CharCr);
            w = close_line();
            return 1'b1;
         end
         line_started = 1'b1;
         if (dropping) return 1'b0;
         if (c == csv_pkg::CharNul) begin
            dropping = 1'b1;
            return 1'b0;
         end
         line_has_content = 1'b1;
         case (mode)
            csv_pkg::MODE_START: begin
               if (c == csv_pkg::CharQuote) begin
                  mode = csv_pkg::MODE_QUOTED;
                  return 1'b0;
               end
               if (c == csv_pkg::CharComma) begin
                  w = end_field();
                  return 1'b1;
               end
               mode = csv_pkg::MODE_UNQUOTED;
            end
            csv_pkg::MODE_QUOTED: begin
               if (c == csv_pkg::CharQuote) begin
                  mode = csv_pkg::MODE_QUOTE_SEEN;
                  return 1'b0;
               end
            end
            csv_pkg::MODE_QUOTE_SEEN: begin
               if (c == csv_pkg::CharComma) begin
                  w = end_field();
                  return 1'b1;
               end
               if (c == csv_pkg::CharQuote) begin
                  mode = csv_pkg::MODE_QUOTED;
               end else begin
                  mode = csv_pkg::MODE_TAIL;
               end
            end
            default: begin
               if (c == csv_pkg::CharComma) begin
                  w = end_field();
                  return 1'b1;
               end
            end
         endcase
         w = make_word(c, 1'b1, 1'b0, 1'b0, 9'd0);
         return 1'b1;
      endfunction

      function void note_input_byte(csv_pkg::req_word_type in_word);
         csv_pkg::rsp_word_type w;
         words_noted++;
         if (parse_byte(in_word, w)) parsed_words.push_back(w);
      endfunction

      function void check_parsed_word(csv_pkg::rsp_word_type got);
         csv_pkg::rsp_word_type want;
         if (parsed_words.size() == 0) begin
            $error("result word with nothing expected: %p", got);
            errors++;
            return;
         end
         want = parsed_words.pop_front();
         words_checked++;
         if (got.end_of_record) records_closed++;
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte expected %0h actual %0h", want.out_byte, got.out_byte);
            errors++;
         end
         if (got.has_byte !== want.has_byte) begin
            $error("has_byte expected %0b actual %0b", want.has_byte, got.has_byte);
            errors++;
         end
         if (got.field_index !== want.field_index) begin
            $error("field_index expected %0d actual %0d", want.field_index, got.field_index);
            errors++;
         end
         if (got.end_of_field !== want.end_of_field) begin
            $error("end_of_field expected %0b actual %0b", want.end_of_field,
                   got.end_of_field);
            errors++;
         end
         if (got.end_of_record !== want.end_of_record) begin
            $error("end_of_record expected %0b actual %0b", want.end_of_record,
                   got.end_of_record);
            errors++;
         end
         if (got.field_count !== want.field_count) begin
            $error("field_count expected %0d actual %0d", want.field_count, got.field_count);
            errors++;
         end
      endfunction
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   csv_pkg::req_word_type req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   csv_pkg::rsp_word_type rsp_word;

   csv_parse_tracker tracker = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_off_req   = 1'b0;
   int words_sent     = 0;
   int quiet_cycles   = 0;

   csv_line_field_splitter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #1 clock = ~clock;

   // watch both channels at each edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) tracker.note_input_byte(req_word);
      if (!reset && rsp_valid && !rsp_stall) tracker.check_parsed_word(rsp_word);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   // receiver: random stalls, or one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HoldOffCycles) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // hang guard
   initial begin
      while (quiet_cycles < QuietLimit) @(posedge clock);
      $display("no handshake for %0d cycles", QuietLimit);
      $display("FAIL csv_line_field_splitter");
      $finish;
   end

   // offer one word, with a random gap first, and wait until it is taken
   task automatic send_word(input logic [7:0] b, input logic eoi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_word.data_byte <= b;
      req_word.end_of_input <= eoi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255));
      while (b inside {csv_pkg::CharQuote, csv_pkg::CharComma, csv_pkg::CharCr,
                       csv_pkg::CharLf, csv_pkg::CharNul});
      return b;
   endfunction

   // any byte, with the special characters weighted up
   function automatic logic [7:0] noise_byte();
      case ($urandom_range(9))
         0:       return csv_pkg::CharQuote;
         1:       return csv_pkg::CharComma;
         2:       return csv_pkg::CharCr;
         3:       return csv_pkg::CharLf;
         4:       return csv_pkg::CharNul;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // one line with random content, not always well-formed, and a random terminator
   task automatic send_record();
      int nfields;
      int len;
      int f;
      int k;
      nfields = $urandom_range(0, 6);
      for (f = 0; f < nfields; f++) begin
         if (f > 0) send_word(csv_pkg::CharComma, 1'b0);
         len = $urandom_range(0, 5);
         case ($urandom_range(3))
            0: begin
               send_word(csv_pkg::CharQuote, 1'b0);
               for (k = 0; k < len; k++) begin
                  case ($urandom_range(5))
                     0: begin
                        send_word(csv_pkg::CharQuote, 1'b0);
                        send_word(csv_pkg::CharQuote, 1'b0);
                     end
                     1:       send_word(csv_pkg::CharComma, 1'b0);
                     default: send_word(plain_byte(), 1'b0);
                  endcase
               end
               if ($urandom_range(5) != 0) send_word(csv_pkg::CharQuote, 1'b0);
               if ($urandom_range(3) == 0) send_word(plain_byte(), 1'b0);
            end
            1: for (k = 0; k < len; k++) begin
               send_word(($urandom_range(3) == 0) ? noise_byte() : plain_byte(), 1'b0);
            end
            default: for (k = 0; k < len; k++) send_word(plain_byte(), 1'b0);
         endcase
      end
      case ($urandom_range(3))
         0: send_word(csv_pkg::CharCr, 1'b0);
         1: send_word(csv_pkg::CharLf, 1'b0);
         2: begin
            send_word(csv_pkg::CharCr, 1'b0);
            send_word(csv_pkg::CharLf, 1'b0);
         end
         default: send_word(8'($urandom_range(255)), 1'b1);
      endcase
   endtask

   // mostly whole lines, some loose noise words
   task automatic run_phase(input int s_pct, input int r_pct, input int n_words);
      int stop_at;
      send_idle_pct  = s_pct;
      recv_stall_pct = r_pct;
      stop_at        = words_sent + n_words;
      while (words_sent < stop_at) begin
         if ($urandom_range(99) < 85) send_record();
         else send_word(noise_byte(), $urandom_range(9) == 0);
      end
   endtask

   initial begin
      int n;
      send_idle_pct  = 16;
      recv_stall_pct = 61;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // quoted field with comma, doubled quote and tail, then a top byte
      send_word(csv_pkg::CharQuote, 1'b0);
      send_word(8'h61, 1'b0);
      send_word(csv_pkg::CharComma, 1'b0);
      send_word(csv_pkg::CharQuote, 1'b0);
      send_word(csv_pkg::CharQuote, 1'b0);
      send_word(csv_pkg::CharQuote, 1'b0);
      send_word(8'h78, 1'b0);
      send_word(csv_pkg::CharComma, 1'b0);
      send_word(8'hFF, 1'b0);
      // cr lf pair, then an empty line
      send_word(csv_pkg::CharCr, 1'b0);
      send_word(csv_pkg::CharLf, 1'b0);
      send_word(csv_pkg::CharLf, 1'b0);
      // line opening with nul has no fields
      send_word(csv_pkg::CharNul, 1'b0);
      send_word(8'h71, 1'b0);
      send_word(csv_pkg::CharCr, 1'b0);
      // nul in mid line drops the rest
      send_word(8'h62, 1'b0);
      send_word(csv_pkg::CharNul, 1'b0);
      send_word(8'h7A, 1'b0);
      send_word(csv_pkg::CharLf, 1'b0);
      // unterminated quote closed by end of input, then a bare end of input
      send_word(csv_pkg::CharQuote, 1'b0);
      send_word(csv_pkg::CharComma, 1'b0);
      send_word(8'hFF, 1'b1);
      send_word(8'h00, 1'b1);
      // empty leading field
      send_word(csv_pkg::CharComma, 1'b0);
      send_word(csv_pkg::CharLf, 1'b0);

      // one line wide enough to saturate index and count
      n = $urandom_range(270, 310);
      repeat (n) send_word(csv_pkg::CharComma, 1'b0);
      send_word(8'h41, 1'b0);
      send_word(csv_pkg::CharLf, 1'b0);

      run_phase(16, 61, PhaseWords);
      run_phase(61, 16, PhaseWords);

      // long receiver hold-off while words keep coming
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_req   = 1'b1;
      repeat (40) send_word(plain_byte(), 1'b0);
      send_word(csv_pkg::CharLf, 1'b0);
      run_phase(0, 0, PhaseWords);

      req_valid <= 1'b0;
      while (tracker.parsed_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (tracker.parsed_words.size() != 0) begin
         $error("%0d expected words never arrived", tracker.parsed_words.size());
         tracker.errors++;
      end
      $display("covered %0d input words, %0d result words, %0d records", tracker.words_noted,
               tracker.words_checked, tracker.records_closed);
      $display("quoting, cr/lf endings, nul drops, end of input and field saturation exercised");
      if (tracker.errors == 0) begin
         $display("PASS csv_line_field_splitter");
      end else begin
         $display("FAIL csv_line_field_splitter");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/csv_pkg.sv
hw/rtl/csv_line_field_splitter.sv
dv/tb_csv_line_field_splitter.sv
